// ===== src/lbp_pkg.sv =====
// Shared types, register codes and helper functions of the 3x3 LBP pixel stream.
// Used by the window cells and the top level; depends on nothing.
package lbp_pkg;

    localparam int PIX_W = 8;
    localparam int ROW_W = 12;
    localparam int COL_W = 10;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 12;
    localparam int WIDTH_REG_W = 11;
    localparam int HEIGHT_REG_W = 12;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH  = 2'd0,
        REG_IMAGE_HEIGHT = 2'd1
    } t_reg_idx;

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
    } t_pix;

    typedef struct packed {
        logic [ROW_W-1:0] out_row;
        logic [COL_W-1:0] out_col;
        logic [PIX_W-1:0] out_value;
        logic             is_code;
        logic             last_in_run;
    } t_res;

    typedef struct packed {
        logic [CFG_IDX_W-1:0]  reg_idx;
        logic [CFG_DATA_W-1:0] wdata;
    } t_cfg;

    // One window column: top, middle and bottom rows.
    typedef struct packed {
        logic [PIX_W-1:0] top;
        logic [PIX_W-1:0] mid;
        logic [PIX_W-1:0] bot;
    } t_col;

    typedef struct packed {
        logic top;
        logic mid;
        logic bot;
    } t_ge;

    function automatic t_ge col_ge(input t_col col, input logic [PIX_W-1:0] ctr);
        t_ge ge;
        ge.top = (col.top >= ctr);
        ge.mid = (col.mid >= ctr);
        ge.bot = (col.bot >= ctr);
        return ge;
    endfunction

endpackage

// ===== src/lbp_stream_if.sv =====
// Valid/ready stream interface whose payload type is a parameter.
// Carries pixel, result and configuration beats; payload types come from lbp_pkg.
interface lbp_stream_if #(
    parameter type t_payload = logic
) ();
    logic     valid;
    logic     ready;
    t_payload data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== src/lbp_line_ram.sv =====
// One line buffer: a single-port-write, single-port-read memory with registered read data.
// Depends on nothing outside this file.
module lbp_line_ram #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10,
    parameter int DW    = 8
) (
    input  logic          i_clk,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output logic [DW-1:0] o_rd_data,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [DW-1:0] i_wr_data
);
    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
endmodule

// ===== src/lbp_col_cell.sv =====
// One window cell: holds a three-pixel column, passes it on when the window shifts,
// and compares its pixels against the window centre. Depends on lbp_pkg.
module lbp_col_cell (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_shift,
    input  lbp_pkg::t_col                 i_col,
    input  logic [lbp_pkg::PIX_W-1:0]     i_ctr,
    output lbp_pkg::t_col                 o_col,
    output lbp_pkg::t_ge                  o_ge
);
    lbp_pkg::t_col r_col;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
        end else if (i_shift) begin
            r_col <= i_col;
        end
    end

    assign o_col = r_col;
    assign o_ge  = lbp_pkg::col_ge(r_col, i_ctr);
endmodule

// ===== src/lbp_3x3_pixel_stream.sv =====
// 3x3 local binary pattern over a raster pixel stream, with two line buffers and a window of cells.
// A pixel is registered in the window stage, and its results then in the output register.
// Throughput: one pixel per cycle while o_res is ready; a pixel that yields both a code and a border
// copy holds the input until both are sent, as the single output register takes one result per cycle.
// Reset (i_rst_n low, synchronous): width 640 or MAX_WIDTH if smaller, height 480, position 0,0,
// pipeline empty; line buffers are not cleared. Depends on lbp_pkg, lbp_stream_if, lbp_line_ram, lbp_col_cell.
module lbp_3x3_pixel_stream #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    lbp_stream_if.sink        i_pix,
    lbp_stream_if.sink        i_cfg,
    lbp_stream_if.source      o_res
);
    localparam int CW = $clog2(MAX_WIDTH);
    localparam int PW = lbp_pkg::PIX_W;
    localparam int RW = lbp_pkg::ROW_W;
    localparam int RST_WIDTH = (MAX_WIDTH < 640) ? MAX_WIDTH : 640;

    logic [RW-1:0] r_row, n_row;
    logic [CW-1:0] r_col, n_col;
    logic [CW-1:0] r_last_col, n_last_col;
    logic [RW-1:0] r_last_row, n_last_row;

    logic          r_s1_valid;
    logic          r_s1_code_pend;
    logic          r_s1_brd_pend;
    logic [PW-1:0] r_s1_px;
    logic [RW-1:0] r_s1_row;
    logic [CW-1:0] r_s1_col;
    logic          r_fwd;
    logic [PW-1:0] r_fwd_top;
    logic [PW-1:0] r_fwd_mid;

    logic          r_out_valid;
    lbp_pkg::t_res r_out, n_out;

    logic          in_fire, cfg_fire, cfg_hit;
    logic          out_free, s1_emit, s1_done;
    logic          need_code, need_brd;
    logic [PW-1:0] ram_top, ram_mid;
    lbp_pkg::t_col cur_col, col_a, col_b;
    lbp_pkg::t_ge  ge_cur, ge_a, ge_b;
    logic [PW-1:0] code;
    logic [31:0]   w_req;
    logic [RW-1:0] h_req;

    // Handshakes.
    assign i_cfg.ready = 1'b1;
    assign cfg_fire    = i_cfg.valid;
    assign in_fire     = i_pix.valid && i_pix.ready;
    assign out_free    = !r_out_valid || o_res.ready;
    assign s1_emit     = r_s1_valid && (r_s1_code_pend || r_s1_brd_pend) && out_free;
    assign s1_done     = r_s1_valid && ((!r_s1_code_pend && !r_s1_brd_pend)
                         || (s1_emit && !(r_s1_code_pend && r_s1_brd_pend)));
    assign i_pix.ready = !r_s1_valid || s1_done;

    // Configuration decode.
    always_comb begin
        cfg_hit    = 1'b0;
        n_last_col = r_last_col;
        n_last_row = r_last_row;
        w_req      = 32'(i_cfg.data.wdata[lbp_pkg::WIDTH_REG_W-1:0]);
        h_req      = i_cfg.data.wdata[lbp_pkg::HEIGHT_REG_W-1:0];
        if (w_req == 32'd0) begin
            w_req = 32'd1;
        end
        if (w_req > 32'(MAX_WIDTH)) begin
            w_req = 32'(MAX_WIDTH);
        end
        if (h_req == '0) begin
            h_req = RW'(1);
        end
        unique case (i_cfg.data.reg_idx)
            lbp_pkg::REG_IMAGE_WIDTH: begin
                cfg_hit    = 1'b1;
                n_last_col = CW'(w_req - 32'd1);
            end
            lbp_pkg::REG_IMAGE_HEIGHT: begin
                cfg_hit    = 1'b1;
                n_last_row = h_req - RW'(1);
            end
            default: begin
                cfg_hit = 1'b0;
            end
        endcase
    end

    // Position of the next pixel.
    always_comb begin
        n_row = r_row;
        n_col = r_col;
        if (in_fire) begin
            if (r_col == r_last_col) begin
                n_col = '0;
                n_row = (r_row == r_last_row) ? '0 : r_row + RW'(1);
            end else begin
                n_col = r_col + CW'(1);
            end
        end
    end

    assign need_code = (r_row >= RW'(2)) && (r_col >= CW'(2));
    assign need_brd  = (r_row == '0) || (r_row == r_last_row)
                       || (r_col == '0) || (r_col == r_last_col);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row      <= '0;
            r_col      <= '0;
            r_last_col <= CW'(RST_WIDTH - 1);
            r_last_row <= RW'(480 - 1);
        end else if (cfg_fire && cfg_hit) begin
            r_row      <= '0;
            r_col      <= '0;
            r_last_col <= n_last_col;
            r_last_row <= n_last_row;
        end else begin
            r_row <= n_row;
            r_col <= n_col;
        end
    end

    // Window stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid     <= 1'b0;
            r_s1_code_pend <= 1'b0;
            r_s1_brd_pend  <= 1'b0;
        end else if (in_fire) begin
            r_s1_valid     <= 1'b1;
            r_s1_code_pend <= need_code;
            r_s1_brd_pend  <= need_brd;
        end else if (s1_done) begin
            r_s1_valid     <= 1'b0;
            r_s1_code_pend <= 1'b0;
            r_s1_brd_pend  <= 1'b0;
        end else if (s1_emit) begin
            r_s1_code_pend <= 1'b0;
        end
    end

    // With a width of one, the column read now is the one the window stage writes now.
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_px   <= i_pix.data.pixel;
            r_s1_row  <= r_row;
            r_s1_col  <= r_col;
            r_fwd     <= s1_done && (r_s1_col == r_col);
            r_fwd_top <= cur_col.mid;
            r_fwd_mid <= r_s1_px;
        end
    end

    lbp_line_ram #(.DEPTH(MAX_WIDTH), .AW(CW), .DW(PW)) u_line_prev2 (
        .i_clk     (i_clk),
        .i_rd_en   (in_fire),
        .i_rd_addr (r_col),
        .o_rd_data (ram_top),
        .i_wr_en   (s1_done),
        .i_wr_addr (r_s1_col),
        .i_wr_data (cur_col.mid)
    );

    lbp_line_ram #(.DEPTH(MAX_WIDTH), .AW(CW), .DW(PW)) u_line_prev (
        .i_clk     (i_clk),
        .i_rd_en   (in_fire),
        .i_rd_addr (r_col),
        .o_rd_data (ram_mid),
        .i_wr_en   (s1_done),
        .i_wr_addr (r_s1_col),
        .i_wr_data (r_s1_px)
    );

    assign cur_col.top = r_fwd ? r_fwd_top : ram_top;
    assign cur_col.mid = r_fwd ? r_fwd_mid : ram_mid;
    assign cur_col.bot = r_s1_px;

    lbp_col_cell u_cell_a (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_shift (s1_done),
        .i_col   (cur_col),
        .i_ctr   (col_a.mid),
        .o_col   (col_a),
        .o_ge    (ge_a)
    );

    lbp_col_cell u_cell_b (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_shift (s1_done),
        .i_col   (col_a),
        .i_ctr   (col_a.mid),
        .o_col   (col_b),
        .o_ge    (ge_b)
    );

    assign ge_cur = lbp_pkg::col_ge(cur_col, col_a.mid);
    assign code   = {ge_b.top, ge_a.top, ge_cur.top, ge_cur.mid,
                     ge_cur.bot, ge_a.bot, ge_b.bot, ge_b.mid};

    // Output register.
    always_comb begin
        if (r_s1_code_pend) begin
            n_out.out_row     = r_s1_row - RW'(1);
            n_out.out_col     = lbp_pkg::COL_W'(r_s1_col - CW'(1));
            n_out.out_value   = code;
            n_out.is_code     = 1'b1;
            n_out.last_in_run = !r_s1_brd_pend;
        end else begin
            n_out.out_row     = r_s1_row;
            n_out.out_col     = lbp_pkg::COL_W'(r_s1_col);
            n_out.out_value   = r_s1_px;
            n_out.is_code     = 1'b0;
            n_out.last_in_run = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= s1_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_emit) begin
            r_out <= n_out;
        end
    end

    assign o_res.valid = r_out_valid;
    assign o_res.data  = r_out;

    a_col_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_col <= r_last_col)
        else $error("Column position is beyond the last column.");

    a_row_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_row <= r_last_row)
        else $error("Row position is beyond the last row.");

    a_code_interior: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.is_code) |-> (r_out.out_row != '0 && r_out.out_col != '0))
        else $error("A code beat was emitted for a border pixel.");

    a_fwd_width_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_fwd) |-> (r_last_col == '0))
        else $error("Line buffer bypass taken with a width above one.");

    a_empty_item_leaves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !r_s1_code_pend && !r_s1_brd_pend) |=>
        !(r_s1_valid && !r_s1_code_pend && !r_s1_brd_pend && $stable(r_s1_col)
          && $past(!in_fire)))
        else $error("A pixel without results stalled in the window stage.");
endmodule
